### src/lse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lse_pkg: shared definitions for the LIFO stack engine
// Operation and status codes, the command word passed from front to back,
// and the default stack depth.
// ============================================================================
package lse_pkg;

    localparam int LSE_DEPTH   = 64;
    localparam int WORD_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int QUEUE_DEPTH = 2;

    // Operation codes as they arrive on the input stream.
    localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
    localparam logic [OP_W-1:0] OP_POP     = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP    = 3'd4;
    // All undefined codes are folded onto this one by the front end.
    localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_VALUE   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DONE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

endpackage : lse_pkg
`default_nettype wire

### src/lse_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lse_front: command intake and queue
// Accepts words from the input stream, folds undefined operation codes onto
// a single unknown code, and holds the commands in a two-entry queue.
// ============================================================================
module lse_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [lse_pkg::WORD_W-1:0] s_axis_tdata,
    input  wire logic [lse_pkg::OP_W-1:0]   s_axis_tuser,
    output logic                            cmd_valid,
    output lse_pkg::cmd_t                   cmd,
    input  wire logic                       cmd_pop
);
    import lse_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               push_en;
    logic               pop_en;
    cmd_t               classified;

    // Classification: codes above dump all mean the same thing.
    always_comb
    begin
        classified.value = s_axis_tdata;
        if (s_axis_tuser > OP_DUMP)
        begin
            classified.op = OP_UNKNOWN;
        end
        else
        begin
            classified.op = s_axis_tuser;
        end
    end

    assign s_axis_tready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign push_en       = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = (fill_reg != '0);
    assign pop_en        = cmd_pop && cmd_valid;
    assign cmd           = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_en && !pop_en)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop_en && !push_en)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            queue_mem[wr_ptr_reg] <= classified;
        end
    end

endmodule : lse_front
`default_nettype wire

### src/lse_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lse_back: stack execution unit
// Owns the stack memory and the entry count, carries out one command at a
// time and drives the result stream through an output register.
// ============================================================================
module lse_back #(
    parameter int DEPTH = lse_pkg::LSE_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    input  wire lse_pkg::cmd_t                cmd,
    output logic                              cmd_pop,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [lse_pkg::WORD_W-1:0]        m_axis_tdata,
    output logic [lse_pkg::STATUS_W-1:0]      m_axis_tuser,
    output logic                              m_axis_tlast
);
    import lse_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic [WORD_W-1:0]   stack_mem [DEPTH];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;

    logic                state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic                dump_reg, dump_next;
    logic                final_reg, final_next;

    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_data_reg, out_data_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic                out_free;
    logic [CW-1:0]       count_m1;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign count_m1 = count_reg - CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        dump_next       = dump_reg;
        final_next      = final_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        cmd_pop         = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = count_m1[AW-1:0];
        wr_en           = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop         = 1'b1;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    unique case (cmd.op)
                        OP_PUSH:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                count_next      = count_reg + CW'(1);
                                out_status_next = STAT_DONE;
                            end
                        end
                        OP_POP, OP_PEEK, OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                // The word is read through the registered memory port and is ready in the next cycle.
                                out_valid_next = 1'b0;
                                rd_en          = 1'b1;
                                state_next     = S_READ;
                                idx_next       = count_m1[AW-1:0];
                                dump_next      = (cmd.op == OP_DUMP);
                                final_next     = (cmd.op != OP_DUMP) || (count_reg == CW'(1));
                                if (cmd.op == OP_POP)
                                begin
                                    count_next = count_m1;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next      = '0;
                            out_status_next = STAT_DONE;
                        end
                        default:
                        begin
                            out_status_next = STAT_UNKNOWN;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = rd_data_reg;
                    out_status_next = STAT_VALUE;
                    out_last_next   = final_reg;
                    if (dump_reg && !final_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_reg - AW'(1);
                        idx_next   = idx_reg - AW'(1);
                        final_next = (idx_reg == AW'(1));
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        dump_reg       <= dump_next;
        final_reg      <= final_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[count_reg[AW-1:0]] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule : lse_back
`default_nettype wire

### src/lifo_stack_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lifo_stack_engine_core: bounded LIFO stack of signed 32-bit words
// Push, pop, peek, clear and dump operations on a stack held in one memory.
// ============================================================================
// Result path: push, clear and unknown-command results pass through the command
//   queue and the output register; pop and peek also pass the registered memory read.
// Throughput: one push, clear or unknown command per cycle, and in a dump one
//   word per cycle after the first read of the single registered memory read
//   port, while results are not stalled; a pop or peek waits out its memory read.
// Reset: rst_n clears the entry count, queue and output valid at once; memory
//   contents are left as they are and no clearing pass is run.
module lifo_stack_engine_core #(
    parameter int DEPTH = lse_pkg::LSE_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Input stream: one operation per word.
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [lse_pkg::WORD_W-1:0]   s_axis_tdata,  // [31:0] push_value
    input  wire logic [lse_pkg::OP_W-1:0]     s_axis_tuser,  // [2:0] operation
    // Result stream.
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [lse_pkg::WORD_W-1:0]        m_axis_tdata,  // [31:0] read_value
    output logic [lse_pkg::STATUS_W-1:0]      m_axis_tuser,  // [2:0] status
    output logic                              m_axis_tlast   // last_of_run
);
    import lse_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // The front end takes operation words and queues them, so that while the queue
    // has room a new word is accepted while the back end waits on the result stream.
    lse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    // The back end owns the stack memory and entry count. It starts a new
    // command only once the output register can take its result, and a dump
    // streams the stored words from the top down, marking the bottom one.
    lse_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule : lifo_stack_engine_core
`default_nettype wire

### src/lse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lse_checker: port-level checks for the LIFO stack engine
// Watches the result stream of the top level over time.
// ============================================================================
module lse_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    input  wire logic [lse_pkg::WORD_W-1:0]   m_axis_tdata,
    input  wire logic [lse_pkg::STATUS_W-1:0] m_axis_tuser,
    input  wire logic                       m_axis_tlast
);
    import lse_pkg::*;

    // A stalled result holds its word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Only a value result carries a word.
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_VALUE) |-> (m_axis_tdata == '0))
        else $error("non-value result carries data");

    // Every status other than a value ends its run.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_VALUE) |-> m_axis_tlast)
        else $error("single result not marked last");

    // A run of dumped words never contains a status result in its middle.
    a_run_values: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
            |-> (m_axis_tuser == STAT_VALUE))
        else $error("dump run interrupted by a status result");

endmodule : lse_checker

bind lifo_stack_engine_core lse_checker u_lse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
